@@ rtl/lbpe_pkg.sv @@
// shared types, codes and the control program for the lsb-first bit packer
// used by lbpe_seq and lsb_first_bit_packer_with_escape_code; no dependencies
package lbpe_pkg;

	// stream commands
	localparam logic [1:0] CMD_RAW    = 2'd0;
	localparam logic [1:0] CMD_PACKED = 2'd1;
	localparam logic [1:0] CMD_ALIGN  = 2'd2;
	localparam logic [1:0] CMD_REWIND = 2'd3;

	// register indexes on the config port
	localparam logic REG_BYTE_ALIGNED = 1'b0;
	localparam logic REG_MAX_BYTES    = 1'b1;

	localparam logic [23:0] MaxBytesReset = 24'd4096;
	localparam int          ResDepth      = 9;
	localparam logic [3:0]  MaxResults    = 4'd9;

	// datapath operations, one per control word
	typedef logic [2:0] op_t;
	localparam op_t OP_WAIT   = 3'd0;
	localparam op_t OP_RAWLD  = 3'd1;
	localparam op_t OP_PKLD   = 3'd2;
	localparam op_t OP_PKSEG  = 3'd3;
	localparam op_t OP_ALN    = 3'd4;
	localparam op_t OP_PUT    = 3'd5;
	localparam op_t OP_EMIT   = 3'd6;
	localparam op_t OP_RWD    = 3'd7;

	// sequencing conditions
	typedef logic [2:0] cond_t;
	localparam cond_t C_NEXT     = 3'd0;
	localparam cond_t C_DISPATCH = 3'd1;
	localparam cond_t C_PUT      = 3'd2;
	localparam cond_t C_FILL     = 3'd3;
	localparam cond_t C_EMIT     = 3'd4;

	// program steps
	typedef logic [3:0] pc_t;
	localparam pc_t PC_WAIT    = 4'd0;
	localparam pc_t PC_RAWLD   = 4'd1;
	localparam pc_t PC_RAWPUT  = 4'd2;
	localparam pc_t PC_PKLD    = 4'd3;
	localparam pc_t PC_PKSEG   = 4'd4;
	localparam pc_t PC_PKPUT   = 4'd5;
	localparam pc_t PC_ALIGN   = 4'd6;
	localparam pc_t PC_EMIT    = 4'd7;
	localparam pc_t PC_REWIND  = 4'd8;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   nxt;
		pc_t   alt;
	} ctrl_t;

	// status from the datapath back to the sequencer
	typedef struct packed {
		logic       in_fire;
		logic [1:0] cmd;
		logic       byte_aligned;
		logic       put_done;
		logic       last_seg;
		logic       fill_zero;
		logic       out_done;
	} stat_t;

	// control store: one word per step
	function automatic ctrl_t lbpe_rom(input pc_t pc);
		ctrl_t w;
		unique case (pc)
			PC_WAIT:   w = '{OP_WAIT,  C_DISPATCH, PC_WAIT,   PC_WAIT};
			PC_RAWLD:  w = '{OP_RAWLD, C_NEXT,     PC_RAWPUT, PC_RAWPUT};
			PC_RAWPUT: w = '{OP_PUT,   C_PUT,      PC_EMIT,   PC_EMIT};
			PC_PKLD:   w = '{OP_PKLD,  C_NEXT,     PC_PKSEG,  PC_PKSEG};
			PC_PKSEG:  w = '{OP_PKSEG, C_NEXT,     PC_PKPUT,  PC_PKPUT};
			PC_PKPUT:  w = '{OP_PUT,   C_PUT,      PC_PKSEG,  PC_EMIT};
			PC_ALIGN:  w = '{OP_ALN,   C_FILL,     PC_RAWPUT, PC_EMIT};
			PC_EMIT:   w = '{OP_EMIT,  C_EMIT,     PC_WAIT,   PC_WAIT};
			PC_REWIND: w = '{OP_RWD,   C_NEXT,     PC_EMIT,   PC_EMIT};
			default:   w = '{OP_WAIT,  C_NEXT,     PC_WAIT,   PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/lbpe_seq.sv @@
// step counter and control store walker for the bit packer
// depends on lbpe_pkg for the program, control word and status types
module lbpe_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  lbpe_pkg::stat_t stat,
	output lbpe_pkg::ctrl_t ctrl
);
	import lbpe_pkg::*;

	pc_t pc_q;
	pc_t pc_d;

	assign ctrl = lbpe_rom(pc_q);

	// next step selection
	always_comb begin
		pc_d = pc_q;
		unique case (ctrl.cond)
			C_NEXT: pc_d = ctrl.nxt;
			C_DISPATCH: begin
				if (stat.in_fire) begin
					unique case (stat.cmd)
						CMD_RAW:    pc_d = PC_RAWLD;
						CMD_PACKED: pc_d = stat.byte_aligned ? PC_RAWLD : PC_PKLD;
						CMD_ALIGN:  pc_d = PC_ALIGN;
						CMD_REWIND: pc_d = PC_REWIND;
						default:    pc_d = PC_WAIT;
					endcase
				end
			end
			C_PUT: begin
				if (stat.put_done)
					pc_d = stat.last_seg ? ctrl.alt : ctrl.nxt;
			end
			C_FILL: pc_d = stat.fill_zero ? ctrl.alt : ctrl.nxt;
			C_EMIT: begin
				if (stat.out_done)
					pc_d = ctrl.nxt;
			end
			default: pc_d = PC_WAIT;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= PC_WAIT;
		else
			pc_q <= pc_d;
	end

endmodule

@@ rtl/lsb_first_bit_packer_with_escape_code.sv @@
// Packs fields into an LSB-first byte stream with an escape-coded packed write. One input
// beat is taken at a time: it is accepted, then loaded (plus one step per escape
// segment for packed writes), merged in chunks of up to 8 bits by the bit merger, then
// sent as output beats (completed bytes of the item, at least one), held while the
// receiver stalls. The rate is set by the single 8-bit merge unit, stepped by the microcode
// sequencer. There is no clearing pass after reset. All results of an item are gathered
// before the first one leaves, since every result carries the item's bit count.
module lsb_first_bit_packer_with_escape_code (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // width[6:0], value[70:7], zero[71]
	input  logic [1:0]  s_tuser,  // command[1:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_byte[7:0], overflow[8], bits_written[15:9]
	output logic        m_tuser,  // byte_valid
	output logic        m_tlast,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lbpe_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// config registers
	logic        ba_q;
	logic [23:0] max_q;

	// stream state
	logic [7:0]  pb_q;
	logic [2:0]  fill_q;
	logic [23:0] cnt_q;
	logic        ovf_q;

	// latched beat and work registers
	logic [1:0]  cmd_q;
	logic [6:0]  w_q;
	logic [63:0] val_q;
	logic [63:0] sh_q;
	logic [6:0]  n_q;
	logic [31:0] pv_q;
	logic [5:0]  pw_q;
	logic        last_seg_q;

	// result buffer
	logic [7:0]          rb_q [ResDepth];
	logic [ResDepth-1:0] ro_q;
	logic [3:0]          rn_q;
	logic [3:0]          oi_q;
	logic [6:0]          ib_q;

	logic in_fire;
	logic out_fire;
	logic out_last;
	logic cfg_wr;

	lbpe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// handshakes
	assign s_tready = (ctrl.op == OP_WAIT);
	assign in_fire  = s_tvalid & s_tready;
	assign m_tvalid = (ctrl.op == OP_EMIT);
	assign out_fire = m_tvalid & m_tready;
	assign out_last = (rn_q == 4'd0) || (oi_q == rn_q - 4'd1);

	// output beat
	assign m_tuser = (rn_q != 4'd0);
	assign m_tlast = out_last;
	assign m_tdata = {ib_q,
		(rn_q == 4'd0) ? ovf_q : ro_q[oi_q],
		(rn_q == 4'd0) ? 8'd0 : rb_q[oi_q]};

	// config access, register picked by paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_MAX_BYTES) ? {8'd0, max_q} : {31'd0, ba_q};

	// raw write load: clamp, mask and round in byte mode
	logic [6:0]  rw_w;
	logic [63:0] rw_v;
	logic [63:0] rw_mask;
	logic [6:0]  rw_up;
	always_comb begin
		if (cmd_q == CMD_PACKED) begin
			rw_w = 7'd32;
			rw_v = {32'd0, val_q[31:0]};
		end else begin
			rw_w = (w_q > 7'd64) ? 7'd64 : w_q;
			rw_v = val_q;
		end
		rw_mask = rw_w[6] ? {64{1'b1}} : ~({64{1'b1}} << rw_w[5:0]);
		rw_up   = rw_w + 7'd7;
	end

	// escape segment: ones marker and next width
	logic [31:0] pk_ones;
	logic        pk_full;
	logic        pk_final;
	logic [5:0]  pk_w2;
	logic [5:0]  pk_start;
	assign pk_ones  = ~(32'hFFFF_FFFF << pw_q[4:0]);
	assign pk_full  = pw_q[5];
	assign pk_final = pk_full || (pv_q < pk_ones);
	assign pk_w2    = pw_q[4] ? 6'd32 : {pw_q[4:0], 1'b0};
	assign pk_start = (w_q > 7'd32) ? 6'd32 : ((w_q == 7'd0) ? 6'd1 : w_q[5:0]);

	// bit merger: one chunk up to the next byte boundary
	logic [3:0]  room;
	logic [3:0]  take;
	logic [3:0]  fsum;
	logic        full;
	logic [7:0]  chunk;
	logic [7:0]  merged;
	logic [23:0] cnt_inc;
	logic        cnt_ge;
	logic        inc_ge;
	logic        put_skip;
	logic        put_abort;
	logic        put_step;
	logic        put_emit;
	logic        put_done;
	always_comb begin
		room      = 4'd8 - {1'b0, fill_q};
		take      = (n_q < {3'd0, room}) ? n_q[3:0] : room;
		fsum      = {1'b0, fill_q} + take;
		full      = fsum[3];
		chunk     = sh_q[7:0] & ~(8'hFF << take);
		merged    = pb_q | (chunk << fill_q);
		cnt_inc   = cnt_q + 24'd1;
		cnt_ge    = (cnt_q >= max_q);
		inc_ge    = (cnt_inc >= max_q);
		put_skip  = ovf_q | cnt_ge | (n_q == 7'd0);
		put_abort = !put_skip && full && (rn_q >= MaxResults);
		put_step  = !put_skip && !put_abort;
		put_emit  = put_step && full;
		put_done  = put_skip | put_abort |
			(put_step && ((n_q == {3'd0, take}) || (full && inc_ge)));
	end

	// status to the sequencer
	always_comb begin
		stat.in_fire      = in_fire;
		stat.cmd          = s_tuser;
		stat.byte_aligned = ba_q;
		stat.put_done     = put_done;
		stat.last_seg     = last_seg_q;
		stat.fill_zero    = (fill_q == 3'd0);
		stat.out_done     = out_fire & out_last;
	end

	// control and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ba_q   <= 1'b0;
			max_q  <= MaxBytesReset;
			pb_q   <= 8'd0;
			fill_q <= 3'd0;
			cnt_q  <= 24'd0;
			ovf_q  <= 1'b0;
			rn_q   <= 4'd0;
			oi_q   <= 4'd0;
			ib_q   <= 7'd0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_BYTE_ALIGNED)
					ba_q <= pwdata[0];
				else
					max_q <= pwdata[23:0];
			end
			case (ctrl.op)
				OP_WAIT: begin
					if (in_fire) begin
						rn_q <= 4'd0;
						oi_q <= 4'd0;
						ib_q <= 7'd0;
					end
				end
				OP_RWD: begin
					pb_q   <= 8'd0;
					fill_q <= 3'd0;
					cnt_q  <= 24'd0;
					ovf_q  <= 1'b0;
				end
				OP_PUT: begin
					if (!ovf_q && cnt_ge) begin
						ovf_q <= 1'b1;
					end else if (put_abort) begin
						// result buffer full: drop the partial byte and stop
						ovf_q  <= 1'b1;
						ib_q   <= ib_q - {4'd0, fill_q};
						pb_q   <= 8'd0;
						fill_q <= 3'd0;
					end else if (put_step) begin
						ib_q <= ib_q + {3'd0, take};
						if (full) begin
							cnt_q  <= cnt_inc;
							ovf_q  <= inc_ge;
							rn_q   <= rn_q + 4'd1;
							pb_q   <= 8'd0;
							fill_q <= 3'd0;
						end else begin
							pb_q   <= merged;
							fill_q <= fsum[2:0];
						end
					end
				end
				OP_EMIT: begin
					if (out_fire)
						oi_q <= oi_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	// work registers and result buffer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= s_tuser;
			w_q   <= s_tdata[6:0];
			val_q <= s_tdata[70:7];
		end
		case (ctrl.op)
			OP_RAWLD: begin
				sh_q       <= ba_q ? (rw_v & rw_mask) : rw_v;
				n_q        <= ba_q ? {rw_up[6:3], 3'd0} : rw_w;
				last_seg_q <= 1'b1;
			end
			OP_PKLD: begin
				pv_q <= val_q[31:0];
				pw_q <= pk_start;
			end
			OP_PKSEG: begin
				n_q        <= pk_full ? 7'd32 : {1'b0, pw_q};
				last_seg_q <= pk_final;
				if (pk_final) begin
					sh_q <= {32'd0, pv_q};
				end else begin
					// escape marker, then move on at the doubled width, capped at 32
					sh_q <= {32'd0, pk_ones};
					pv_q <= pv_q - pk_ones;
					pw_q <= pk_w2;
				end
			end
			OP_ALN: begin
				sh_q       <= 64'd0;
				n_q        <= {3'd0, room};
				last_seg_q <= 1'b1;
			end
			OP_PUT: begin
				if (put_step) begin
					sh_q <= sh_q >> take;
					n_q  <= n_q - {3'd0, take};
				end
				if (put_emit) begin
					rb_q[rn_q] <= merged;
					ro_q[rn_q] <= inc_ge;
				end
				if (put_abort)
					ro_q[rn_q - 4'd1] <= 1'b1;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_rn_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rn_q <= MaxResults)
		else $error("result count beyond buffer depth");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_PUT && put_emit) |=> (fill_q == 3'd0))
		else $error("partial byte not cleared after emission");

	a_ovf_no_growth: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_PUT && ovf_q) |=> $stable(rn_q))
		else $error("byte emitted while overflow set");

	a_sides_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while results pending");
`endif

endmodule

@@ tb/tb_top.sv @@
// testbench for the lsb-first bit packer: directed and random streams checked beat by beat
// against a packer model kept in step with the accepted input beats
// depends on lbpe_pkg and lsb_first_bit_packer_with_escape_code
`timescale 1ns / 100ps

module tb_top;
	import lbpe_pkg::*;

	typedef struct {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic       overflow;
		logic [6:0] bits_written;
	} stream_beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;  // width[6:0], value[70:7], zero[71]
	logic [1:0]  s_tuser  = CMD_RAW;  // command[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;  // out_byte[7:0], overflow[8], bits_written[15:9]
	logic        m_tuser;  // byte_valid
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// packer model: register copies and stream state
	logic        cfg_aligned   = 1'b0;
	logic [23:0] cfg_max_bytes = MaxBytesReset;
	logic [7:0]  acc_byte      = '0;
	int          acc_fill      = 0;
	logic [23:0] bytes_out     = '0;
	logic        ovf_flag      = 1'b0;
	logic [7:0]  item_byte [ResDepth];
	logic        item_ovf [ResDepth];
	int          item_count;
	int          item_bits;

	stream_beat_t expected_bytes[$];
	int           err_count    = 0;
	int           burst_left   = 0;
	bit           sender_idles = 1'b0;
	logic [7:0]   ready_mask   = 8'hFF;
	logic [2:0]   ready_phase  = '0;

	lsb_first_bit_packer_with_escape_code dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver stalls follow a rotating 8-bit ready mask
	always @(posedge clk) begin
		m_tready    <= ready_mask[ready_phase];
		ready_phase <= ready_phase + 3'd1;
	end

	// append the low n bits of v, lsb first
	function automatic void append_bits(logic [63:0] v, int n);
		int room;
		int take;
		if (ovf_flag) return;
		if (bytes_out >= cfg_max_bytes) begin
			ovf_flag = 1'b1;
			return;
		end
		while (n > 0) begin
			room = 8 - acc_fill;
			take = (n < room) ? n : room;
			// a tenth byte does not fit in one item's results
			if (acc_fill + take == 8 && item_count >= ResDepth) begin
				ovf_flag = 1'b1;
				item_bits -= acc_fill;
				acc_byte = '0;
				acc_fill = 0;
				item_ovf[item_count - 1] = 1'b1;
				return;
			end
			acc_byte = acc_byte | 8'((v & ((64'd1 << take) - 64'd1)) << acc_fill);
			v = v >> take;
			n -= take;
			acc_fill += take;
			item_bits += take;
			if (acc_fill == 8) begin
				bytes_out = bytes_out + 24'd1;
				if (bytes_out >= cfg_max_bytes) ovf_flag = 1'b1;
				item_byte[item_count] = acc_byte;
				item_ovf[item_count] = ovf_flag;
				item_count++;
				acc_byte = '0;
				acc_fill = 0;
				if (ovf_flag) return;
			end
		end
	endfunction

	function automatic void append_raw(int w, logic [63:0] v);
		if (w > 64) w = 64;
		if (cfg_aligned) begin
			if (w < 64) v = v & ((64'd1 << w) - 64'd1);
			w = (w + 7) & ~7;
		end
		append_bits(v, w);
	endfunction

	// escape code: all ones at width w means subtract and double the width
	function automatic void append_escaped(int w, logic [31:0] v);
		logic [31:0] ones;
		bit          done;
		if (cfg_aligned) begin
			append_raw(32, {32'd0, v});
			return;
		end
		if (w == 0) w = 1;
		if (w > 32) w = 32;
		done = 1'b0;
		while (!done) begin
			if (w >= 32) begin
				append_bits({32'd0, v}, 32);
				done = 1'b1;
			end else begin
				ones = (32'd1 << w) - 32'd1;
				if (v < ones) begin
					append_bits({32'd0, v}, w);
					done = 1'b1;
				end else begin
					append_bits({32'd0, ones}, w);
					v = v - ones;
					w = w * 2;
					if (w > 32) w = 32;
				end
			end
		end
	endfunction

	// work out the beats one accepted input beat causes
	function automatic void pack_item(logic [1:0] cmd, logic [6:0] w, logic [63:0] v);
		stream_beat_t beat;
		item_count = 0;
		item_bits  = 0;
		case (cmd)
			CMD_RAW:    append_raw(int'(w), v);
			CMD_PACKED: append_escaped(int'(w), v[31:0]);
			CMD_ALIGN:  if (acc_fill != 0) append_bits(64'd0, 8 - acc_fill);
			CMD_REWIND: begin
				acc_byte  = '0;
				acc_fill  = 0;
				bytes_out = '0;
				ovf_flag  = 1'b0;
			end
		endcase
		if (item_count == 0) begin
			beat.out_byte     = '0;
			beat.byte_valid   = 1'b0;
			beat.last         = 1'b1;
			beat.overflow     = ovf_flag;
			beat.bits_written = 7'(item_bits);
			expected_bytes.push_back(beat);
		end else begin
			for (int k = 0; k < item_count; k++) begin
				beat.out_byte     = item_byte[k];
				beat.byte_valid   = 1'b1;
				beat.last         = (k == item_count - 1);
				beat.overflow     = item_ovf[k];
				beat.bits_written = 7'(item_bits);
				expected_bytes.push_back(beat);
			end
		end
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endfunction

	// compare each output beat with the oldest expected one
	always @(posedge clk) begin : check_beats
		stream_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				$error("output beat with nothing expected: tdata %h", m_tdata);
				err_count++;
			end else begin
				want = expected_bytes.pop_front();
				check_field("out_byte", want.out_byte, m_tdata[7:0]);
				check_field("byte_valid", 8'(want.byte_valid), 8'(m_tuser));
				check_field("last", 8'(want.last), 8'(m_tlast));
				check_field("overflow", 8'(want.overflow), 8'(m_tdata[8]));
				check_field("bits_written", 8'(want.bits_written), 8'(m_tdata[15:9]));
			end
		end
	end

	// sender: bursts of random length, random gaps between them when sender_idles is set
	task automatic send_item(input logic [1:0] cmd, input logic [6:0] w, input logic [63:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = sender_idles ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, v, w};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		pack_item(cmd, w, v);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	// config write: setup then access
	task automatic write_reg(input logic idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_BYTE_ALIGNED) cfg_aligned = data[0];
		else cfg_max_bytes = data[23:0];
	endtask

	// raw writes at the width extremes, align and rewind
	task automatic test_raw_fields();
		send_item(CMD_RAW, 7'd0, {$urandom, $urandom});
		send_item(CMD_RAW, 7'd1, 64'd1);
		send_item(CMD_RAW, 7'd7, '1);
		send_item(CMD_RAW, 7'd64, '1);
		send_item(CMD_RAW, 7'd127, 64'h8000_0000_0000_0001);
		send_item(CMD_RAW, 7'd3, 64'd5);
		send_item(CMD_ALIGN, 7'd0, 64'd0);
		send_item(CMD_ALIGN, 7'd0, 64'd0);
		send_item(CMD_RAW, 7'd5, 64'h1F);
		send_item(CMD_REWIND, 7'd0, 64'd0);
		drain_results();
	endtask

	// packed writes: just below and at the escape, chained escapes, width clamps
	task automatic test_escape_code();
		send_item(CMD_PACKED, 7'd0, 64'd0);
		send_item(CMD_PACKED, 7'd5, 64'd30);
		send_item(CMD_PACKED, 7'd5, 64'd31);
		send_item(CMD_PACKED, 7'd1, 64'hFFFF_FFFF);
		send_item(CMD_PACKED, 7'd127, 64'hFFFF_0000_DEAD_BEEF);
		send_item(CMD_PACKED, 7'd32, 64'd0);
		drain_results();
	endtask

	// byte mode switched on while a partial byte is held
	task automatic test_byte_mode();
		send_item(CMD_RAW, 7'd3, 64'd3);
		drain_results();
		write_reg(REG_BYTE_ALIGNED, 32'd1);
		send_item(CMD_RAW, 7'd5, 64'hFF);
		send_item(CMD_PACKED, 7'd4, 64'd123456789);
		send_item(CMD_RAW, 7'd0, '1);
		send_item(CMD_ALIGN, 7'd0, 64'd0);
		send_item(CMD_REWIND, 7'd0, 64'd0);
		drain_results();
		write_reg(REG_BYTE_ALIGNED, 32'd0);
	endtask

	// overflow mid-write, dropped writes, write starting past the limit, rewind
	task automatic test_overflow();
		write_reg(REG_MAX_BYTES, 32'd1);
		send_item(CMD_RAW, 7'd16, 64'hABCD);
		send_item(CMD_RAW, 7'd8, 64'h55);
		send_item(CMD_ALIGN, 7'd0, 64'd0);
		send_item(CMD_REWIND, 7'd0, 64'd0);
		drain_results();
		write_reg(REG_MAX_BYTES, 32'd4096);
		send_item(CMD_RAW, 7'd24, 64'h12_3456);
		drain_results();
		write_reg(REG_MAX_BYTES, 32'd2);
		send_item(CMD_RAW, 7'd8, 64'h5A);
		send_item(CMD_REWIND, 7'd0, 64'd0);
		drain_results();
		write_reg(REG_MAX_BYTES, 32'h00FF_FFFF);
		send_item(CMD_RAW, 7'd64, {$urandom, $urandom});
		drain_results();
	endtask

	// random commands over several register settings and idle patterns
	task automatic test_random_mix();
		logic [1:0]  cmd;
		logic [6:0]  w;
		logic [63:0] v;
		logic [31:0] limit_bytes;
		int          pick;
		for (int phase = 0; phase < 8; phase++) begin
			write_reg(REG_BYTE_ALIGNED, $urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0:       limit_bytes = 32'd1;
				1:       limit_bytes = $urandom_range(2, 12);
				2:       limit_bytes = $urandom_range(13, 60);
				3:       limit_bytes = 32'h00FF_FFFF;
				default: limit_bytes = 32'd4096;
			endcase
			write_reg(REG_MAX_BYTES, limit_bytes);
			sender_idles = (phase != 0) && ($urandom_range(0, 3) != 0);
			ready_mask <= (phase == 0 || $urandom_range(0, 3) == 0) ?
				8'hFF : 8'($urandom_range(1, 254));
			for (int n = 0; n < 30; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 42) begin
					cmd = CMD_RAW;
					w = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127)) :
						7'($urandom_range(0, 64));
				end else if (pick < 80) begin
					cmd = CMD_PACKED;
					if ($urandom_range(0, 9) == 0) w = 7'($urandom_range(33, 127));
					else if ($urandom_range(0, 1) == 0) w = 7'($urandom_range(0, 6));
					else w = 7'($urandom_range(7, 32));
				end else begin
					cmd = (pick < 94) ? CMD_ALIGN : CMD_REWIND;
					w = 7'($urandom_range(0, 127));
				end
				// small values, all ones, values around the escape, or anything
				case ($urandom_range(0, 4))
					0:       v = 64'($urandom_range(0, 7));
					1:       v = '1;
					2:       v = (64'd1 << (w % 32)) - 64'd2 + 64'($urandom_range(0, 2));
					default: v = {$urandom, $urandom};
				endcase
				send_item(cmd, w, v);
			end
			drain_results();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_raw_fields();
		test_escape_code();
		test_byte_mode();
		test_overflow();
		test_random_mix();
		repeat (16) @(posedge clk);
		if (err_count == 0) $display("tb_top: done, clean");
		else $display("tb_top: done, errors");
		$finish;
	end

	// run limit
	initial begin
		#(2_000_000);
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lbpe_pkg.sv
rtl/lbpe_seq.sv
rtl/lsb_first_bit_packer_with_escape_code.sv
tb/tb_top.sv
